// ===== rtl/srev_pkg.sv =====
package srev_pkg;

    // wide accumulator used for products, sums and saturation
    localparam int ACC_W = 48;

    localparam int WET_W = 17;
    localparam logic [WET_W-1:0] WET_ONE    = 17'd65536;
    localparam logic [WET_W-1:0] WET_BYPASS = 17'd65;
    localparam logic [WET_W-1:0] WET_RESET  = 17'd19661;

    // comb feedback gains, Q0.16
    localparam int GAIN_W = 17;
    localparam int NUM_COMBS = 4;
    localparam logic [GAIN_W-1:0] COMB_GAIN [NUM_COMBS] = '{
        17'd52756, 17'd54198, 17'd51315, 17'd50070
    };

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_WET_MIX = 1'b0;

    // output queue; power of two
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic signed [ACC_W-1:0] HALF1  = 48'sd1;
    localparam logic signed [ACC_W-1:0] HALF2  = 48'sd2;
    localparam logic signed [ACC_W-1:0] HALF16 = 48'sd32768;

    function automatic logic signed [ACC_W-1:0] sat_to(
        input logic signed [ACC_W-1:0] v,
        input int                      bits
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) << (bits - 1)) - ACC_W'(1);
        lo = ~hi;
        if (v > hi) begin
            sat_to = hi;
        end else if (v < lo) begin
            sat_to = lo;
        end else begin
            sat_to = v;
        end
    endfunction

endpackage

// ===== rtl/schroeder_reverb.sv =====
// Schroeder reverberator: four parallel feedback combs, averaged, then two
// series all-pass stages, mixed with the dry input by the wet_mix register.
// Input channel s_*: one Q1.15 sample and a block_last flag per transfer.
// Output channel m_*: one mixed sample and the same flag per input sample,
// in order. Configuration is an APB port; wet_mix (Q1.16) sits at address 0.
// The user is to write wet_mix only while no sample is in flight; the block
// itself does not enforce this. A sample passes the comb, first all-pass,
// second all-pass and mix stages, then the output queue, before it is offered
// on m_valid. Throughput: one sample per cycle while s_ready is high; every
// delay line is one RAM, read one stage and written the next, so each line port is used once per sample.
// Reset empties all lines without a clearing pass: each line tracks its
// first wrap and reads zero before it. wet_mix returns to 19661.
// When the receiver stalls, finished samples collect in an 8-entry output
// queue; s_ready drops once samples in the pipeline plus those in the queue
// reach 8, so nothing in the pipeline ever waits.
module schroeder_reverb
    import srev_pkg::*;
#(
    parameter int SAMPLE_RATE         = 48000,
    parameter int SAMPLE_BITS         = 16,
    parameter int ALLPASS_B_MS_TENTHS = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          s_block_last,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_block_last_out
);

    localparam int MEM_W = SAMPLE_BITS + 4;

    localparam int LEN_CA_RAW = (SAMPLE_RATE * 297) / 10000;
    localparam int LEN_CB_RAW = (SAMPLE_RATE * 371) / 10000;
    localparam int LEN_CC_RAW = (SAMPLE_RATE * 411) / 10000;
    localparam int LEN_CD_RAW = (SAMPLE_RATE * 437) / 10000;
    localparam int LEN_AA_RAW = (SAMPLE_RATE * 50) / 10000;
    localparam int LEN_AB_RAW = (SAMPLE_RATE * ALLPASS_B_MS_TENTHS) / 10000;
    localparam int LEN_AA = (LEN_AA_RAW > 0) ? LEN_AA_RAW : 1;
    localparam int LEN_AB = (LEN_AB_RAW > 0) ? LEN_AB_RAW : 1;
    localparam int COMB_LEN [NUM_COMBS] = '{
        (LEN_CA_RAW > 0) ? LEN_CA_RAW : 1,
        (LEN_CB_RAW > 0) ? LEN_CB_RAW : 1,
        (LEN_CC_RAW > 0) ? LEN_CC_RAW : 1,
        (LEN_CD_RAW > 0) ? LEN_CD_RAW : 1
    };

    localparam int FIFO_AW = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W   = $clog2(OUT_FIFO_DEPTH + 1);

    // configuration
    logic [WET_W-1:0] wet_mix_reg;
    logic [WET_W-1:0] wet_eff;
    logic             bypass_now;

    // pipeline stages
    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic                          byp1_reg, byp2_reg, byp3_reg, byp4_reg;
    logic                          last1_reg, last2_reg, last3_reg, last4_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [WET_W-1:0]              wet1_reg, wet2_reg, wet3_reg, wet4_reg;
    logic signed [MEM_W-1:0]       rev2_reg, ya3_reg, yb4_reg;

    // delay lines
    logic                    s_xfer;
    logic                    comb_rd_en;
    logic signed [MEM_W-1:0] comb_rd [NUM_COMBS];
    logic signed [MEM_W-1:0] comb_wr [NUM_COMBS];
    logic signed [ACC_W-1:0] comb_prod [NUM_COMBS];
    logic signed [ACC_W-1:0] comb_acc [NUM_COMBS];
    logic signed [ACC_W-1:0] comb_sum;
    logic signed [ACC_W-1:0] rev_acc;
    logic signed [MEM_W-1:0] rev_next;

    logic signed [MEM_W-1:0] apa_rd, apa_wr, ya_next;
    logic signed [MEM_W-1:0] apb_rd, apb_wr, yb_next;
    logic signed [ACC_W-1:0] apa_y_acc, apa_w_acc, apb_y_acc, apb_w_acc;

    // mix
    logic [WET_W-1:0]              wet_gap;
    logic signed [ACC_W-1:0]       mix_acc;
    logic signed [ACC_W-1:0]       mix_sat;
    logic signed [SAMPLE_BITS-1:0] result;

    // output queue
    logic signed [SAMPLE_BITS-1:0] out_sample_mem [OUT_FIFO_DEPTH];
    logic                          out_last_mem [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0]            wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]              occ_reg, occ_next;
    logic [CNT_W-1:0]              credit_reg, credit_next;
    logic                          m_xfer;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_mix_reg <= WET_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_WET_MIX)) begin
            wet_mix_reg <= pwdata[WET_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_WET_MIX) begin
            prdata = DATA_W'(wet_mix_reg);
        end else begin
            prdata = '0;
        end
    end

    assign wet_eff    = (wet_mix_reg > WET_ONE) ? WET_ONE : wet_mix_reg;
    assign bypass_now = (wet_eff <= WET_BYPASS);

    // input side
    assign s_ready    = (credit_reg < CNT_W'(OUT_FIFO_DEPTH));
    assign s_xfer     = s_valid && s_ready;
    assign comb_rd_en = s_xfer && !bypass_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= s_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        byp1_reg  <= bypass_now;
        last1_reg <= s_block_last;
        x1_reg    <= s_sample_in;
        wet1_reg  <= wet_eff;

        byp2_reg  <= byp1_reg;
        last2_reg <= last1_reg;
        x2_reg    <= x1_reg;
        wet2_reg  <= wet1_reg;
        rev2_reg  <= rev_next;

        byp3_reg  <= byp2_reg;
        last3_reg <= last2_reg;
        x3_reg    <= x2_reg;
        wet3_reg  <= wet2_reg;
        ya3_reg   <= ya_next;

        byp4_reg  <= byp3_reg;
        last4_reg <= last3_reg;
        x4_reg    <= x3_reg;
        wet4_reg  <= wet3_reg;
        yb4_reg   <= yb_next;
    end

    // stage 1: comb read data, feedback write, average of the four outputs
    for (genvar i = 0; i < NUM_COMBS; i++) begin : g_comb
        srev_line #(
            .DEPTH(COMB_LEN[i]),
            .WIDTH(MEM_W)
        ) u_comb (
            .aclk    (aclk),
            .aresetn (aresetn),
            .rd_en   (comb_rd_en),
            .wr_data (comb_wr[i]),
            .rd_data (comb_rd[i])
        );
    end

    always_comb begin
        for (int i = 0; i < NUM_COMBS; i++) begin
            comb_prod[i] = comb_rd[i] * $signed({1'b0, COMB_GAIN[i]});
            comb_acc[i]  = sat_to(x1_reg + ((comb_prod[i] + HALF16) >>> 16), MEM_W);
            comb_wr[i]   = comb_acc[i][MEM_W-1:0];
        end
        comb_sum = comb_rd[0] + comb_rd[1] + comb_rd[2] + comb_rd[3];
        rev_acc  = sat_to((comb_sum + HALF2) >>> 2, MEM_W);
        rev_next = rev_acc[MEM_W-1:0];
    end

    // stage 2: first all-pass
    srev_line #(
        .DEPTH(LEN_AA),
        .WIDTH(MEM_W)
    ) u_allpass_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (v1_reg && !byp1_reg),
        .wr_data (apa_wr),
        .rd_data (apa_rd)
    );

    always_comb begin
        apa_y_acc = sat_to(apa_rd - rev2_reg, MEM_W);
        apa_w_acc = sat_to(rev2_reg + ((apa_rd + HALF1) >>> 1), MEM_W);
        ya_next   = apa_y_acc[MEM_W-1:0];
        apa_wr    = apa_w_acc[MEM_W-1:0];
    end

    // stage 3: second all-pass
    srev_line #(
        .DEPTH(LEN_AB),
        .WIDTH(MEM_W)
    ) u_allpass_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (v2_reg && !byp2_reg),
        .wr_data (apb_wr),
        .rd_data (apb_rd)
    );

    always_comb begin
        apb_y_acc = sat_to(apb_rd - ya3_reg, MEM_W);
        apb_w_acc = sat_to(ya3_reg + ((apb_rd + HALF1) >>> 1), MEM_W);
        yb_next   = apb_y_acc[MEM_W-1:0];
        apb_wr    = apb_w_acc[MEM_W-1:0];
    end

    // stage 4: dry/wet mix
    always_comb begin
        wet_gap = WET_ONE - wet4_reg;
        mix_acc = x4_reg * $signed({1'b0, wet_gap})
                + yb4_reg * $signed({1'b0, wet4_reg})
                + HALF16;
        mix_sat = sat_to(mix_acc >>> 16, SAMPLE_BITS);
        if (byp4_reg) begin
            result = x4_reg;
        end else begin
            result = mix_sat[SAMPLE_BITS-1:0];
        end
    end

    // output queue
    assign m_valid          = (occ_reg != '0);
    assign m_xfer           = m_valid && m_ready;
    assign m_sample_out     = out_sample_mem[rd_ptr_reg];
    assign m_block_last_out = out_last_mem[rd_ptr_reg];

    always_comb begin
        occ_next    = occ_reg + CNT_W'(v4_reg) - CNT_W'(m_xfer);
        credit_next = credit_reg + CNT_W'(s_xfer) - CNT_W'(m_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
            credit_reg <= '0;
        end else begin
            occ_reg    <= occ_next;
            credit_reg <= credit_next;
            if (v4_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (m_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg) begin
            out_sample_mem[wr_ptr_reg] <= result;
            out_last_mem[wr_ptr_reg]   <= last4_reg;
        end
    end

endmodule

// ===== rtl/srev_ram.sv =====
module srev_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 240
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/srev_line.sv =====
module srev_line #(
    parameter int DEPTH = 240,
    parameter int WIDTH = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic signed [WIDTH-1:0] wr_data,
    output logic signed [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic [AW-1:0]    addr_reg;
    logic             full_reg;
    logic             full_rd_reg;
    logic             pend_reg;
    logic             hit_reg;
    logic [WIDTH-1:0] hit_data_reg;
    logic [WIDTH-1:0] ram_rd_data;

    always_comb begin
        if (ptr_reg == LAST) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    // the line is written in order, so an entry holds data once the pointer has wrapped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            full_reg    <= 1'b0;
            full_rd_reg <= 1'b0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            pend_reg <= rd_en;
            if (rd_en) begin
                ptr_reg     <= ptr_next;
                full_rd_reg <= full_reg;
                // read and write of the same entry at one edge: take the write data
                hit_reg     <= pend_reg && (addr_reg == ptr_reg);
                if (ptr_reg == LAST) begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_reg <= ptr_reg;
        end
        hit_data_reg <= wr_data;
    end

    srev_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (pend_reg),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        if (hit_reg) begin
            rd_data = hit_data_reg;
        end else if (full_rd_reg) begin
            rd_data = ram_rd_data;
        end else begin
            rd_data = '0;
        end
    end

endmodule
